### design/ppos_pkg.sv
// Package with shared constants, types and register codes of the pair overlap search.
`default_nettype none
package ppos_pkg;
    localparam int MaxEntries = 1024;
    localparam int CellW      = 10;
    localparam int CoordInW   = 31;
    localparam int PosW       = 32;
    localparam int RadW       = 30;
    localparam int BoxW       = 30;
    localparam int CountW     = 11;
    localparam int IdxInW     = 10;
    localparam int PaddrW     = 5;

    typedef enum logic [2:0] {
        RegMode  = 3'd0,
        RegBoxX  = 3'd1,
        RegBoxY  = 3'd2,
        RegBoxZ  = 3'd3,
        RegWrapX = 3'd4,
        RegWrapY = 3'd5,
        RegWrapZ = 3'd6
    } t_reg;

    typedef enum logic [1:0] {
        ModeAll  = 2'd0,
        ModeXy   = 2'd1,
        ModeOpen = 2'd2,
        ModeNone = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        StIdle,
        StRead,
        StTest,
        StSum,
        StShift,
        StDone
    } t_state;
endpackage
`default_nettype wire

### design/ppos_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface ppos_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [9:0]  index;
    logic [9:0]  start_second;
    logic [10:0] entry_count;
    logic [9:0]  cell_x;
    logic [9:0]  cell_y;
    logic [9:0]  cell_z;
    logic signed [30:0] coord_x;
    logic signed [30:0] coord_y;
    logic signed [30:0] coord_z;
    logic [29:0] sphere_radius;
    modport source (output valid, req_type, index, start_second, entry_count, cell_x, cell_y,
        cell_z, coord_x, coord_y, coord_z, sphere_radius, input ready);
    modport sink (input valid, req_type, index, start_second, entry_count, cell_x, cell_y,
        cell_z, coord_x, coord_y, coord_z, sphere_radius, output ready);
endinterface

interface ppos_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [10:0] first_index;
    logic [9:0]  second_index;
    logic signed [31:0] shifted_x;
    logic signed [31:0] shifted_y;
    logic signed [31:0] shifted_z;
    modport source (output valid, found, first_index, second_index, shifted_x, shifted_y,
        shifted_z, input ready);
    modport sink (input valid, found, first_index, second_index, shifted_x, shifted_y,
        shifted_z, output ready);
endinterface
`default_nettype wire

### design/periodic_pair_overlap_search.sv
// Top level of the pair overlap search: entry table memory, pair scan sequencer and APB registers.
//  channel  | direction | transfer when
//  req      | in        | valid & ready
//  res      | out       | valid & ready
//  apb      | in        | psel & penable & pwrite (pready tied high)
// A write request has its result valid in the cycle after its transfer.
// A search reads and latches each first entry, then reads each second entry and tests the pair on
// its cell and bound, skipping an equal index and moving to the next row at the end of a row; every
// entry is fetched through the single read port of the entry memories. A pair that passes sums
// its squares axis by axis; a hit adds a position write-back, then the done state sets the result.
// Requests are refused while a search runs or a result waits. Reset is synchronous and
// clears control state and registers; the table is undefined until written.
`default_nettype none
module periodic_pair_overlap_search #(
    parameter int MAX_ENTRIES = ppos_pkg::MaxEntries
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    ppos_req_if.sink                    req,
    ppos_res_if.source                  res,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [ppos_pkg::PaddrW-1:0]  paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ppos_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = (AW + 1 > CountW) ? AW + 1 : CountW;

    // Registers.
    logic [1:0]       r_mode;
    logic [BoxW-1:0]  r_box [3];
    logic [CellW-1:0] r_wrap [3];

    // Entry memories.
    logic [3*CellW-1:0] mem_cell [MAX_ENTRIES];
    logic [PosW-1:0]    mem_pos  [3][MAX_ENTRIES];
    logic [RadW-1:0]    mem_rad  [MAX_ENTRIES];
    logic [3*CellW-1:0] rd_cell;
    logic [PosW-1:0]    rd_pos [3];
    logic [RadW-1:0]    rd_rad;

    logic         mem_we_all, mem_we_pos;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [3*CellW-1:0] wr_cell;
    logic [PosW-1:0]    wr_pos [3];
    logic [RadW-1:0]    wr_rad;

    t_state r_state, n_state;
    logic [CW-1:0] r_p1, n_p1, r_p2, n_p2, r_cnt;
    logic          r_side;  // 0 reading p1, 1 reading p2
    logic [3*CellW-1:0] r_ca;
    logic [PosW-1:0]    r_pa [3];
    logic [RadW-1:0]    r_ra;
    logic [1:0]         r_dir [3];     // bit1 valid, bit0 raise(1)/reduce(0)
    logic [RadW:0]      r_rsum;
    logic [RadW:0]      r_mag [3];
    logic               r_cand;
    logic [2*RadW+3:0]  r_acc;
    logic               r_hit;
    logic [1:0]         r_axis;

    logic          r_out_v, r_found;
    logic [10:0]   r_out_i1;
    logic [9:0]    r_out_i2;
    logic [PosW-1:0] r_out_pos [3];

    wire req_xfer = req.valid && req.ready;
    wire res_xfer = res.valid && res.ready;
    wire wr_req   = req_xfer && !req.req_type;
    wire sr_req   = req_xfer && req.req_type;

    assign req.ready = (r_state == StIdle) && !r_out_v;
    assign pready = 1'b1;

    // APB registers.
    wire cfg_wr = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeAll;
            for (int a = 0; a < 3; a++) begin
                r_box[a]  <= BoxW'(65536);
                r_wrap[a] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (paddr[PaddrW-1:2])
                RegMode:  r_mode    <= pwdata[1:0];
                RegBoxX:  r_box[0]  <= pwdata[BoxW-1:0];
                RegBoxY:  r_box[1]  <= pwdata[BoxW-1:0];
                RegBoxZ:  r_box[2]  <= pwdata[BoxW-1:0];
                RegWrapX: r_wrap[0] <= pwdata[CellW-1:0];
                RegWrapY: r_wrap[1] <= pwdata[CellW-1:0];
                RegWrapZ: r_wrap[2] <= pwdata[CellW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[PaddrW-1:2])
            RegMode:  prdata = {30'd0, r_mode};
            RegBoxX:  prdata = {2'd0, r_box[0]};
            RegBoxY:  prdata = {2'd0, r_box[1]};
            RegBoxZ:  prdata = {2'd0, r_box[2]};
            RegWrapX: prdata = {22'd0, r_wrap[0]};
            RegWrapY: prdata = {22'd0, r_wrap[1]};
            RegWrapZ: prdata = {22'd0, r_wrap[2]};
            default:  prdata = '0;
        endcase
    end

    // Memory access.
    wire wr_in_range = (32'(req.index) < 32'(MAX_ENTRIES));
    always_comb begin
        mem_we_all = wr_req && wr_in_range;
        mem_we_pos = mem_we_all || (r_state == StShift);
        mem_waddr  = mem_we_all ? AW'(req.index) : r_p1[AW-1:0];
        wr_cell    = {req.cell_z, req.cell_y, req.cell_x};
        wr_rad     = req.sphere_radius;
        for (int a = 0; a < 3; a++) begin
            if (mem_we_all) begin
                wr_pos[a] = (a == 0) ? PosW'(req.coord_x) :
                            (a == 1) ? PosW'(req.coord_y) : PosW'(req.coord_z);
            end else if (r_dir[a] == 2'b10) begin
                wr_pos[a] = r_pa[a] - PosW'(r_box[a]);
            end else if (r_dir[a] == 2'b11) begin
                wr_pos[a] = r_pa[a] + PosW'(r_box[a]);
            end else begin
                wr_pos[a] = r_pa[a];
            end
        end
        mem_raddr = r_side ? r_p2[AW-1:0] : r_p1[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we_all) begin
            mem_cell[mem_waddr] <= wr_cell;
            mem_rad[mem_waddr]  <= wr_rad;
        end
        if (mem_we_pos) begin
            for (int a = 0; a < 3; a++) mem_pos[a][mem_waddr] <= wr_pos[a];
        end
        rd_cell <= mem_cell[mem_raddr];
        rd_rad  <= mem_rad[mem_raddr];
        for (int a = 0; a < 3; a++) rd_pos[a] <= mem_pos[a][mem_raddr];
    end

    // Pair test on the entry just read against the latched first entry.
    wire [RadW:0] sum_rad = {1'b0, r_ra} + {1'b0, rd_rad};
    logic         t_cand;
    logic [1:0]   t_dir [3];
    logic [RadW:0] t_mag [3];
    logic         t_per;
    logic [CellW-1:0] t_dc;
    logic signed [PosW+1:0] t_dr, t_adj;
    logic signed [PosW+2:0] t_twice;
    logic signed [PosW+2:0] t_len;
    logic [PosW+1:0] t_abs;
    always_comb begin
        t_cand = (r_mode != ModeNone);
        t_per = 1'b0; t_dc = '0; t_dr = '0; t_adj = '0; t_twice = '0; t_len = '0; t_abs = '0;
        for (int a = 0; a < 3; a++) begin
            t_per = (r_mode == ModeAll) || (r_mode == ModeXy && a < 2);
            t_dc = (r_ca[a*CellW +: CellW] >= rd_cell[a*CellW +: CellW]) ?
                   r_ca[a*CellW +: CellW] - rd_cell[a*CellW +: CellW] :
                   rd_cell[a*CellW +: CellW] - r_ca[a*CellW +: CellW];
            if (!(t_dc < CellW'(2) || (t_per && t_dc == r_wrap[a]))) t_cand = 1'b0;
            t_dr = $signed({{2{r_pa[a][PosW-1]}}, r_pa[a]}) -
                   $signed({{2{rd_pos[a][PosW-1]}}, rd_pos[a]});
            t_twice = {t_dr, 1'b0};
            t_len = $signed({3'b000, r_box[a]});
            t_dir[a] = 2'b00;
            t_adj = t_dr;
            if (t_per && t_twice > t_len) begin
                t_dir[a] = 2'b10;
                t_adj = t_dr - $signed({4'b0000, r_box[a]});
            end else if (t_per && t_twice < -t_len) begin
                t_dir[a] = 2'b11;
                t_adj = t_dr + $signed({4'b0000, r_box[a]});
            end
            t_abs = t_adj[PosW+1] ? PosW'(0) - t_adj : t_adj;
            if (t_abs > (PosW+2)'(sum_rad)) t_cand = 1'b0;
            t_mag[a] = t_abs[RadW:0];
        end
    end

    // One square per cycle over the three axes.
    wire [2*RadW+1:0] sq = r_mag[r_axis] * r_mag[r_axis];
    wire [2*RadW+1:0] rs2 = r_rsum * r_rsum;

    wire [CW-1:0] p2_next = r_p2 + CW'(1);
    wire [CW-1:0] p1_next = r_p1 + CW'(1);

    // Scan sequencer.
    logic scan_end;
    always_comb begin
        n_p1 = r_p1; n_p2 = r_p2; scan_end = 1'b0;
        if (r_p1 >= r_cnt || r_mode == ModeNone) begin
            scan_end = 1'b1;
        end else if (r_p2 >= r_cnt) begin
            n_p1 = p1_next; n_p2 = '0;
        end else if (r_p2 == r_p1) begin
            n_p2 = p2_next;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            StIdle:  if (sr_req) n_state = StRead;
            StRead: begin
                if (scan_end) begin
                    n_state = StDone;
                end else if (!r_side) begin
                    n_state = StTest;
                end else if (n_p1 != r_p1 || n_p2 != r_p2) begin
                    n_state = StRead;
                end else begin
                    n_state = StTest;
                end
            end
            StTest:  n_state = (r_side && t_cand) ? StSum : StRead;
            StSum:   if (r_axis == 2'd3) n_state = r_hit ? StShift : StRead;
            StShift: n_state = StDone;
            StDone:  n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_side  <= 1'b0;
            r_out_v <= 1'b0;
            r_axis  <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_xfer) r_out_v <= 1'b0;
            unique case (r_state)
                StIdle: begin
                    if (wr_req) begin
                        r_out_v <= 1'b1; r_found <= 1'b0; r_out_i1 <= '0; r_out_i2 <= '0;
                        for (int a = 0; a < 3; a++) r_out_pos[a] <= '0;
                    end
                    if (sr_req) begin
                        r_p1 <= CW'(req.index);
                        r_p2 <= CW'(req.start_second);
                        r_cnt <= (32'(req.entry_count) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                 : CW'(req.entry_count);
                        r_side <= 1'b0;
                    end
                end
                StRead: begin
                    // Address settled; check bounds; the registered read data arrives in the following cycle.
                    if (scan_end) begin
                        r_found <= 1'b0;
                        r_out_i1 <= 11'(r_cnt); r_out_i2 <= '0;
                        for (int a = 0; a < 3; a++) r_out_pos[a] <= '0;
                    end else if (!r_side) begin
                    end else if (n_p1 != r_p1) begin
                        r_p1 <= n_p1; r_p2 <= n_p2; r_side <= 1'b0;
                    end else if (n_p2 != r_p2) begin
                        r_p2 <= n_p2;
                    end
                end
                StTest: begin
                    if (!r_side) begin
                        r_ca <= rd_cell; r_ra <= rd_rad;
                        for (int a = 0; a < 3; a++) r_pa[a] <= rd_pos[a];
                        r_side <= 1'b1;
                    end else if (t_cand) begin
                        r_rsum <= sum_rad;
                        for (int a = 0; a < 3; a++) begin
                            r_mag[a] <= t_mag[a]; r_dir[a] <= t_dir[a];
                        end
                        r_acc <= '0; r_axis <= '0; r_hit <= 1'b0;
                    end else begin
                        r_p2 <= p2_next;
                    end
                end
                StSum: begin
                    if (r_axis != 2'd3) begin
                        r_acc <= r_acc + (2*RadW+4)'(sq);
                        r_axis <= r_axis + 2'd1;
                        if (r_axis == 2'd2) begin
                            r_hit <= (r_mode == ModeOpen) ?
                                ((r_acc + (2*RadW+4)'(sq)) < (2*RadW+4)'(rs2)) :
                                ((r_acc + (2*RadW+4)'(sq)) <= (2*RadW+4)'(rs2));
                        end
                    end else if (!r_hit) begin
                        r_p2 <= p2_next;
                    end
                end
                StShift: begin
                    r_found <= 1'b1;
                    r_out_i1 <= 11'(r_p1);
                    r_out_i2 <= 10'(r_p2);
                    for (int a = 0; a < 3; a++) r_out_pos[a] <= wr_pos[a];
                end
                StDone: begin
                    r_out_v <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign res.valid        = r_out_v;
    assign res.found        = r_found;
    assign res.first_index  = r_out_i1;
    assign res.second_index = r_out_i2;
    assign res.shifted_x    = r_out_pos[0];
    assign res.shifted_y    = r_out_pos[1];
    assign res.shifted_z    = r_out_pos[2];

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> !req.ready) else $error("request taken during a search");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && !res.ready) |=> res.valid) else $error("result dropped");
    a_hit_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StShift) |-> (r_p1 != r_p2 && r_p1 < r_cnt)) else $error("bad hit pair");
`endif
endmodule
`default_nettype wire
